/* rtl/core/bsrw_pkg.sv */
package bsrw_pkg;

  localparam int STORE_BYTES_DEF    = 4096;
  localparam int MAX_FIELD_BITS_DEF = 64;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 7;
  localparam int SKIP_W  = 16;
  localparam int POS_W   = 16;
  localparam int CFG_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BYTE = 3'd0,
    OP_READ_BYTE = 3'd1,
    OP_GET_BITS  = 3'd2,
    OP_PUT_BITS  = 3'd3,
    OP_SKIP_BITS = 3'd4,
    OP_PAD_BYTE  = 3'd5
  } op_t;

  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [7:0] m;
    case (n)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0f;
      4'd5:    m = 8'h1f;
      4'd6:    m = 8'h3f;
      4'd7:    m = 8'h7f;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/bitstream_read_write_cursor.sv */
// Channel   Handshake                      Payload
// request   start, busy (taken: start&!busy) op, byte_address, write_value, bit_count,
//                                            skip_bits, fill_ones
// result    result_valid (one-cycle strobe)  read_data, done_ok, stream_ok, bits_skipped,
//                                            bit_position
// config    cfg_valid, cfg_ready             cfg_data (stream_bytes)
//
// Load byte, failed and empty operations pass through the check, decide and respond states; read
// byte and skip add a read-byte or skip-add state. Get, put and pad add a read and a merge state for
// each byte touched (up to 9): the single-port byte store gives one read, then one merge or write, per byte.
// Synchronous reset clears cursor and stream_bytes and sets the ok flag; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bitstream_read_write_cursor
  import bsrw_pkg::*;
#(
  parameter int STORE_BYTES    = STORE_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [ADDR_W-1:0]  byte_address,
  input  logic [DATA_W-1:0]  write_value,
  input  logic [COUNT_W-1:0] bit_count,
  input  logic [SKIP_W-1:0]  skip_bits,
  input  logic               fill_ones,
  output logic               result_valid,
  output logic [DATA_W-1:0]  read_data,
  output logic               done_ok,
  output logic               stream_ok,
  output logic [SKIP_W-1:0]  bits_skipped,
  output logic [POS_W-1:0]   bit_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int MFB = MAX_FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DECIDE, S_RD, S_MRG, S_RDBYTE, S_SKADD, S_RESP
  } state_t;

  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [24:0] r;
    logic [24:0] d;
    r = 25'(a);
    for (int j = 7; j >= 0; j--) begin
      d = 25'(STORE_BYTES) << j;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[AW-1:0];
  endfunction

  state_t              state;
  op_t                 op_r;
  logic [AW-1:0]       addr_r;
  logic [DATA_W-1:0]   wv_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [SKIP_W-1:0]   skp_r;
  logic                fill_r;
  logic [POS_W-1:0]    cur;
  logic                ok;
  logic [CFG_W-1:0]    stream_bytes;
  logic [POS_W-1:0]    left;
  logic [POS_W-1:0]    pos;
  logic [COUNT_W-1:0]  rem;
  logic [MFB-1:0]      acc;
  logic [MFB-1:0]      shreg;

  logic [7:0]          mem [STORE_BYTES];
  logic [7:0]          rdata;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata;

  logic [CFG_W-1:0]    nbytes;
  logic [POS_W-1:0]    end_bits;
  logic [COUNT_W-1:0]  pad_n;
  logic [COUNT_W-1:0]  n_sel;
  logic [POS_W-1:0]    pos_byte;
  logic [3:0]          avail;
  logic [3:0]          k;
  logic [3:0]          sh;
  logic [7:0]          get_bits;
  logic [7:0]          put_top;
  logic [7:0]          bmask;
  logic [7:0]          merged;
  logic [MFB-1:0]      acc_next;
  logic                is_put;
  logic                last_byte;

  assign busy         = (state != S_IDLE);
  assign cfg_ready    = (state == S_IDLE);
  assign stream_ok    = ok;
  assign bit_position = cur;

  assign nbytes   = ({4'd0, stream_bytes} < 17'(STORE_BYTES)) ? stream_bytes
                                                             : CFG_W'(STORE_BYTES);
  assign end_bits = {nbytes, 3'b000};
  assign pad_n    = COUNT_W'(3'(4'd8 - {1'b0, cur[2:0]}));
  assign n_sel    = (op_r == OP_PAD_BYTE) ? pad_n : cnt_r;
  assign is_put   = (op_r == OP_PUT_BITS) || (op_r == OP_PAD_BYTE);

  assign pos_byte  = {3'b000, pos[POS_W-1:3]};
  assign avail     = 4'd8 - {1'b0, pos[2:0]};
  assign k         = ({3'b000, avail} < rem) ? avail : rem[3:0];
  assign sh        = avail - k;
  assign get_bits  = (rdata >> sh) & low_mask(k);
  assign acc_next  = (acc << k) | MFB'(get_bits);
  assign put_top   = shreg[MFB-1 -: 8] >> (4'd8 - k);
  assign bmask     = low_mask(k) << sh;
  assign merged    = (rdata & ~bmask) | ((put_top << sh) & bmask);
  assign last_byte = (rem == COUNT_W'(k));

  always_comb begin
    mem_addr  = addr_r;
    mem_we    = 1'b0;
    mem_wdata = wv_r[7:0];
    case (state)
      S_DECIDE: begin
        mem_we = (op_r == OP_LOAD_BYTE);
      end
      S_RD: begin
        mem_addr = pos_byte[AW-1:0];
      end
      S_MRG: begin
        mem_addr  = pos_byte[AW-1:0];
        mem_we    = is_put;
        mem_wdata = merged;
      end
      default: begin
        mem_addr = addr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= '0;
      ok           <= 1'b1;
      stream_bytes <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            stream_bytes <= cfg_data;
          end
          if (start) begin
            op_r         <= op_t'(op);
            addr_r       <= wrap_addr(byte_address);
            wv_r         <= write_value;
            cnt_r        <= bit_count;
            skp_r        <= skip_bits;
            fill_r       <= fill_ones;
            read_data    <= '0;
            done_ok      <= 1'b0;
            bits_skipped <= '0;
            state        <= S_CHECK;
          end
        end
        S_CHECK: begin
          left  <= (cur < end_bits) ? (end_bits - cur) : '0;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_RESP;
          case (op_r)
            OP_LOAD_BYTE: begin
              done_ok <= 1'b1;
            end
            OP_READ_BYTE: begin
              state <= S_RDBYTE;
            end
            OP_GET_BITS, OP_PUT_BITS, OP_PAD_BYTE: begin
              if (n_sel > COUNT_W'(MAX_FIELD_BITS) || POS_W'(n_sel) > left) begin
                ok <= 1'b0;
              end else if (n_sel == '0) begin
                done_ok <= 1'b1;
              end else begin
                pos   <= cur;
                rem   <= n_sel;
                acc   <= '0;
                shreg <= (op_r == OP_PUT_BITS)
                         ? (wv_r[MFB-1:0] << (COUNT_W'(MAX_FIELD_BITS) - n_sel))
                         : {MFB{fill_r}};
                state <= S_RD;
              end
            end
            OP_SKIP_BITS: begin
              bits_skipped <= (skp_r < left) ? skp_r : left;
              done_ok      <= (skp_r <= left);
              state        <= S_SKADD;
            end
            default: begin
              done_ok <= 1'b0;
            end
          endcase
        end
        S_RD: begin
          state <= S_MRG;
        end
        S_MRG: begin
          acc   <= acc_next;
          shreg <= shreg << k;
          pos   <= pos + POS_W'(k);
          rem   <= rem - COUNT_W'(k);
          if (last_byte) begin
            if (op_r == OP_GET_BITS) begin
              read_data <= DATA_W'(acc_next);
            end
            cur     <= pos + POS_W'(k);
            done_ok <= 1'b1;
            state   <= S_RESP;
          end else begin
            state <= S_RD;
          end
        end
        S_RDBYTE: begin
          read_data <= DATA_W'(rdata);
          done_ok   <= 1'b1;
          state     <= S_RESP;
        end
        S_SKADD: begin
          cur   <= cur + bits_skipped;
          state <= S_RESP;
        end
        S_RESP: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("block busy while presenting a result");

  a_request_starts_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !result_valid))
    else $error("accepted request did not start work");

  a_ok_sticky: assert property (@(posedge clk) disable iff (rst)
    !stream_ok |=> !stream_ok)
    else $error("ok flag recovered without reset");
`endif

endmodule

/* test/bitstream_read_write_cursor_tb.sv */
`timescale 1ns / 1ps

module bitstream_read_write_cursor_tb;
  import bsrw_pkg::*;

  localparam int STORE_BYTES    = STORE_BYTES_DEF;
  localparam int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF;
  localparam int STALL_LIMIT    = 5000;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  byte_address;
    logic [DATA_W-1:0]  write_value;
    logic [COUNT_W-1:0] bit_count;
    logic [SKIP_W-1:0]  skip_bits;
    logic               fill_ones;
  } cursor_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              done_ok;
    logic              stream_ok;
    logic [SKIP_W-1:0] bits_skipped;
    logic [POS_W-1:0]  bit_position;
  } cursor_res_t;

  typedef struct {
    bit          ok;
    bit          clears;
    int unsigned adv;
  } cursor_move_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    op = '0;
  logic [ADDR_W-1:0]  byte_address = '0;
  logic [DATA_W-1:0]  write_value = '0;
  logic [COUNT_W-1:0] bit_count = '0;
  logic [SKIP_W-1:0]  skip_bits = '0;
  logic               fill_ones = 1'b0;
  logic               result_valid;
  logic [DATA_W-1:0]  read_data;
  logic               done_ok;
  logic               stream_ok;
  logic [SKIP_W-1:0]  bits_skipped;
  logic [POS_W-1:0]   bit_position;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  cursor_req_t pending_ops[$];
  cursor_res_t pending_results[$];

  bit [7:0]    model_store [STORE_BYTES];
  int unsigned model_cursor = 0;
  bit          model_ok = 1'b1;
  int unsigned model_stream_bytes = 0;

  bit          plan_written [STORE_BYTES];
  int unsigned plan_cursor = 0;
  int unsigned plan_stream_bytes = 0;

  int unsigned send_idle_pct = 0;
  int          fail_count = 0;
  int          stall_cycles = 0;

  bitstream_read_write_cursor dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .byte_address (byte_address),
    .write_value  (write_value),
    .bit_count    (bit_count),
    .skip_bits    (skip_bits),
    .fill_ones    (fill_ones),
    .result_valid (result_valid),
    .read_data    (read_data),
    .done_ok      (done_ok),
    .stream_ok    (stream_ok),
    .bits_skipped (bits_skipped),
    .bit_position (bit_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic cursor_move_t cursor_move(cursor_req_t r, int unsigned cur,
                                               int unsigned sbytes);
    cursor_move_t m;
    int unsigned  end_bits;
    int unsigned  avail;
    int unsigned  need;
    m = '{ok: 1'b0, clears: 1'b0, adv: 0};
    end_bits = ((sbytes < STORE_BYTES) ? sbytes : STORE_BYTES) * 8;
    avail = (cur < end_bits) ? end_bits - cur : 0;
    case (r.op)
      OP_LOAD_BYTE, OP_READ_BYTE: begin
        m.ok = 1'b1;
      end
      OP_GET_BITS, OP_PUT_BITS, OP_PAD_BYTE: begin
        need = (r.op == OP_PAD_BYTE) ? (8 - cur % 8) % 8 : r.bit_count;
        m.ok = (need <= MAX_FIELD_BITS) && (need <= avail);
        m.adv = m.ok ? need : 0;
        m.clears = !m.ok;
      end
      OP_SKIP_BITS: begin
        m.adv = (r.skip_bits < avail) ? r.skip_bits : avail;
        m.ok = (m.adv == r.skip_bits);
      end
      default: ;
    endcase
    return m;
  endfunction

  function automatic cursor_res_t apply_cursor_op(cursor_req_t r);
    cursor_res_t  res;
    cursor_move_t m;
    int unsigned  p;
    int unsigned  i;
    m = cursor_move(r, model_cursor, model_stream_bytes);
    res = '0;
    res.done_ok = m.ok;
    case (r.op)
      OP_LOAD_BYTE: begin
        model_store[r.byte_address] = r.write_value[7:0];
      end
      OP_READ_BYTE: begin
        res.read_data = {56'd0, model_store[r.byte_address]};
      end
      OP_GET_BITS: begin
        for (i = 0; i < m.adv; i++) begin
          p = model_cursor + i;
          res.read_data = {res.read_data[DATA_W-2:0], model_store[p >> 3][7 - (p & 7)]};
        end
      end
      OP_PUT_BITS, OP_PAD_BYTE: begin
        for (i = 0; i < m.adv; i++) begin
          p = model_cursor + i;
          model_store[p >> 3][7 - (p & 7)] =
            (r.op == OP_PAD_BYTE) ? r.fill_ones : r.write_value[m.adv - 1 - i];
        end
      end
      OP_SKIP_BITS: begin
        res.bits_skipped = m.adv[SKIP_W-1:0];
      end
      default: ;
    endcase
    if (m.clears) begin
      model_ok = 1'b0;
    end
    model_cursor += m.adv;
    res.stream_ok = model_ok;
    res.bit_position = model_cursor[POS_W-1:0];
    return res;
  endfunction

  function automatic cursor_req_t random_fields();
    cursor_req_t r;
    r.op = OP_W'($urandom_range(0, 7));
    r.byte_address = ADDR_W'($urandom_range(0, STORE_BYTES - 1));
    r.write_value = {$urandom, $urandom};
    r.bit_count = COUNT_W'($urandom);
    r.skip_bits = SKIP_W'($urandom);
    r.fill_ones = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Load any byte that a read, get, put or pad is about to touch for the first time.
  function automatic void ensure_loaded(logic [ADDR_W-1:0] addr);
    cursor_req_t r;
    if (!plan_written[addr]) begin
      r = random_fields();
      r.op = OP_LOAD_BYTE;
      r.byte_address = addr;
      pending_ops.push_back(r);
      plan_written[addr] = 1'b1;
    end
  endfunction

  function automatic void schedule_op(cursor_req_t r);
    cursor_move_t m;
    int unsigned  b;
    m = cursor_move(r, plan_cursor, plan_stream_bytes);
    if (r.op == OP_READ_BYTE) begin
      ensure_loaded(r.byte_address);
    end
    if (r.op inside {OP_GET_BITS, OP_PUT_BITS, OP_PAD_BYTE} && m.adv != 0) begin
      for (b = plan_cursor >> 3; b <= (plan_cursor + m.adv - 1) >> 3; b++) begin
        ensure_loaded(b[ADDR_W-1:0]);
      end
    end
    if (r.op == OP_LOAD_BYTE) begin
      plan_written[r.byte_address] = 1'b1;
    end
    pending_ops.push_back(r);
    plan_cursor += m.adv;
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] code, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] value, logic [COUNT_W-1:0] count,
                                   logic [SKIP_W-1:0] skip, logic fill);
    cursor_req_t r;
    r = '{op: code, byte_address: addr, write_value: value, bit_count: count,
          skip_bits: skip, fill_ones: fill};
    schedule_op(r);
  endfunction

  function automatic void queue_random_op();
    cursor_req_t r;
    int unsigned pick;
    r = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.op = OP_LOAD_BYTE;
    end else if (pick < 20) begin
      r.op = OP_READ_BYTE;
    end else if (pick < 70) begin
      r.op = (pick < 45) ? OP_GET_BITS : OP_PUT_BITS;
      r.bit_count = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(65, 127))
                                                 : COUNT_W'($urandom_range(0, 64));
    end else if (pick < 82) begin
      r.op = OP_SKIP_BITS;
      r.skip_bits = ($urandom_range(0, 6) == 0) ? SKIP_W'($urandom_range(0, 1500))
                                                : SKIP_W'($urandom_range(0, 64));
    end else if (pick < 95) begin
      r.op = OP_PAD_BYTE;
    end else begin
      r.op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    end
    schedule_op(r);
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
    fail_count++;
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_ops.size() != 0 || start || pending_results.size() != 0);
  endtask

  task automatic set_stream_bytes(logic [CFG_W-1:0] value);
    plan_stream_bytes = value;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_stream_bytes = value;
  endtask

  always @(posedge clk) begin : drive_requests
    bit taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        pending_results.push_back(apply_cursor_op(pending_ops.pop_front()));
      end
      if (!start || taken) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          start <= 1'b1;
          op <= pending_ops[0].op;
          byte_address <= pending_ops[0].byte_address;
          write_value <= pending_ops[0].write_value;
          bit_count <= pending_ops[0].bit_count;
          skip_bits <= pending_ops[0].skip_bits;
          fill_ones <= pending_ops[0].fill_ones;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    cursor_res_t want;
    if (!rst) begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", read_data, '0);
        end else begin
          want = pending_results.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", read_data, want.read_data);
          if (done_ok !== want.done_ok)
            report_mismatch("done_ok", done_ok, want.done_ok);
          if (stream_ok !== want.stream_ok)
            report_mismatch("stream_ok", stream_ok, want.stream_ok);
          if (bits_skipped !== want.bits_skipped)
            report_mismatch("bits_skipped", bits_skipped, want.bits_skipped);
          if (bit_position !== want.bit_position)
            report_mismatch("bit_position", bit_position, want.bit_position);
        end
      end
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty stream: loads, reads and zero-length work succeed; the first failed get clears the ok flag
    send_idle_pct = 9;
    set_stream_bytes(13'd0);
    queue_op(OP_LOAD_BYTE, 12'hfff, ALL_ONES, 7'd0, 16'd0, 1'b0);
    queue_op(OP_LOAD_BYTE, 12'h000, 64'h0123_4567_89ab_cd5a, 7'd0, 16'd0, 1'b0);
    queue_op(OP_READ_BYTE, 12'hfff, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_READ_BYTE, 12'h000, ALL_ONES, 7'd127, 16'hffff, 1'b1);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd0, 16'd0, 1'b1);
    queue_op(OP_PAD_BYTE, 12'h000, '0, 7'd0, 16'd0, 1'b1);
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'd1, 1'b0);
    queue_op(OP_SPARE_6, 12'h123, ALL_ONES, 7'd8, 16'd8, 1'b1);
    queue_op(OP_SPARE_7, 12'hfff, ALL_ONES, 7'd8, 16'd8, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd1, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd64, 16'd0, 1'b0);
    wait_for_drain();

    set_stream_bytes(13'd4);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd65, 16'd0, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd127, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd5, 16'd0, 1'b0);
    queue_op(OP_PAD_BYTE, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_READ_BYTE, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd7, 16'd0, 1'b0);
    queue_op(OP_PAD_BYTE, 12'h000, '0, 7'd0, 16'd0, 1'b1);
    queue_op(OP_PUT_BITS, 12'h000, 64'hffff_ffff_ffff_5ac3, 7'd16, 16'd0, 1'b0);
    queue_op(OP_READ_BYTE, 12'h002, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd1, 16'd0, 1'b0);
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    wait_for_drain();

    // lower the end below the cursor
    set_stream_bytes(13'd1);
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'd10, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd0, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd1, 16'd0, 1'b1);
    wait_for_drain();

    set_stream_bytes(13'd1024);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd64, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, '0, 7'd64, 16'd0, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd64, 16'd0, 1'b0);
    repeat (25) queue_random_op();
    wait_for_drain();
    repeat (25) queue_random_op();
    wait_for_drain();

    send_idle_pct = 76;
    set_stream_bytes(13'd2048);
    repeat (50) queue_random_op();
    wait_for_drain();

    send_idle_pct = 0;
    set_stream_bytes(13'd4096);
    repeat (25) queue_random_op();
    wait_for_drain();
    set_stream_bytes(13'h1fff);
    repeat (25) queue_random_op();
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'hffff, 1'b0);
    queue_op(OP_GET_BITS, 12'h000, '0, 7'd1, 16'd0, 1'b0);
    queue_op(OP_PUT_BITS, 12'h000, ALL_ONES, 7'd64, 16'd0, 1'b0);
    queue_op(OP_PAD_BYTE, 12'h000, '0, 7'd0, 16'd0, 1'b1);
    queue_op(OP_SKIP_BITS, 12'h000, '0, 7'd0, 16'd3, 1'b0);
    wait_for_drain();

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
